// ===== hw/rtl/owb_pkg.sv =====
package owb_pkg;

    // Timer width; phase counts above its range saturate
    localparam int TIMER_WIDTH = 16;
    localparam logic [63:0] TIMER_MAX = (64'd1 << TIMER_WIDTH) - 64'd1;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_SAMPLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_TAIL    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_REST   = 3'd6;

    // Request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_RESET = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] reset_low_ticks;
        logic [CFG_DATA_W-1:0] reset_sample_ticks;
        logic [CFG_DATA_W-1:0] reset_tail_ticks;
        logic [CFG_DATA_W-1:0] slot_low_ticks;
        logic [CFG_DATA_W-1:0] read_sample_ticks;
        logic [CFG_DATA_W-1:0] read_tail_ticks;
        logic [CFG_DATA_W-1:0] write_rest_ticks;
    } t_cfg;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       op_done;
        logic [7:0] read_byte;
        logic       presence_level;
        logic       cmd_rejected;
    } t_res;

    // Map a register count to a timer load: zero acts as one, saturate at the top
    function automatic logic [TIMER_WIDTH-1:0] clamp_ticks(input logic [CFG_DATA_W-1:0] v);
        logic [63:0] w;
        w = {{(64-CFG_DATA_W){1'b0}}, v};
        if (w == 64'd0) begin
            w = 64'd1;
        end
        if (w > TIMER_MAX) begin
            w = TIMER_MAX;
        end
        return w[TIMER_WIDTH-1:0];
    endfunction

endpackage

// ===== hw/rtl/owb_in_if.sv =====
interface owb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] write_byte;
    logic       line_level;

    modport source (output valid, output req_type, output write_byte, output line_level,
                    input ready);
    modport sink (input valid, input req_type, input write_byte, input line_level,
                  output ready);
endinterface

// ===== hw/rtl/owb_out_if.sv =====
interface owb_out_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       op_done;
    logic [7:0] read_byte;
    logic       presence_level;
    logic       cmd_rejected;

    modport source (output valid, output drive_low, output busy_res, output op_done,
                    output read_byte, output presence_level, output cmd_rejected,
                    input ready);
    modport sink (input valid, input drive_low, input busy_res, input op_done,
                  input read_byte, input presence_level, input cmd_rejected,
                  output ready);
endinterface

// ===== hw/rtl/one_wire_bus_master.sv =====
// One-wire bus master: one tick transaction in, one result transaction out.
// The result of a tick is loaded into the output register when the tick is accepted.
// Throughput: one tick per cycle; the only limit is the output register, which
// takes a new result whenever it is empty or its result is taken in that cycle.
// Reset (i_rst_n low at a clock edge): bus idle, output empty, registers at defaults.
module one_wire_bus_master (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    owb_in_if.sink                           i_req,
    owb_out_if.source                        o_res,
    input  logic                             i_cfg_we,
    input  logic [owb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [owb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import owb_pkg::*;

    t_cfg cfg;
    t_res res;
    logic can_load;
    logic accept;

    assign i_req.ready = can_load;
    assign accept      = i_req.valid && can_load;

    owb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    owb_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_req_type   (i_req.req_type),
        .i_write_byte (i_req.write_byte),
        .i_line_level (i_req.line_level),
        .i_cfg        (cfg),
        .o_res        (res)
    );

    owb_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_res      (res),
        .o_can_load (can_load),
        .o_res      (o_res)
    );

endmodule

// ===== hw/rtl/owb_cfg.sv =====
module owb_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [owb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [owb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output owb_pkg::t_cfg                    o_cfg
);
    import owb_pkg::*;

    t_cfg r_cfg;

    // Load defaults on reset, then take writes by index; others are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_ticks    <= 16'd500;
            r_cfg.reset_sample_ticks <= 16'd100;
            r_cfg.reset_tail_ticks   <= 16'd400;
            r_cfg.slot_low_ticks     <= 16'd10;
            r_cfg.read_sample_ticks  <= 16'd1;
            r_cfg.read_tail_ticks    <= 16'd60;
            r_cfg.write_rest_ticks   <= 16'd50;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RESET_LOW:    r_cfg.reset_low_ticks    <= i_cfg_data;
                CFG_RESET_SAMPLE: r_cfg.reset_sample_ticks <= i_cfg_data;
                CFG_RESET_TAIL:   r_cfg.reset_tail_ticks   <= i_cfg_data;
                CFG_SLOT_LOW:     r_cfg.slot_low_ticks     <= i_cfg_data;
                CFG_READ_SAMPLE:  r_cfg.read_sample_ticks  <= i_cfg_data;
                CFG_READ_TAIL:    r_cfg.read_tail_ticks    <= i_cfg_data;
                CFG_WRITE_REST:   r_cfg.write_rest_ticks   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/owb_core.sv =====
module owb_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [1:0]     i_req_type,
    input  logic [7:0]     i_write_byte,
    input  logic           i_line_level,
    input  owb_pkg::t_cfg  i_cfg,
    output owb_pkg::t_res  o_res
);
    import owb_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_TAIL = 4'd3,
        PH_W_LOW    = 4'd4,
        PH_W_REST   = 4'd5,
        PH_R_LOW    = 4'd6,
        PH_R_WAIT   = 4'd7,
        PH_R_TAIL   = 4'd8
    } t_phase;

    t_phase                 r_phase,    n_phase;
    logic [TIMER_WIDTH-1:0] r_timer,    n_timer;
    logic [7:0]             r_shift,    n_shift;
    logic [2:0]             r_bit,      n_bit;
    logic                   r_presence, n_presence;
    logic [7:0]             r_read,     n_read;

    t_phase                 e_phase;
    logic [TIMER_WIDTH-1:0] e_timer;
    logic [7:0]             e_shift;
    logic [2:0]             e_bit;
    logic                   busy;
    logic                   done;
    logic                   drive;
    logic                   rej;

    always_comb begin
        // Start a command on an idle tick; that tick is the first of its first phase
        e_phase = r_phase;
        e_timer = r_timer;
        e_shift = r_shift;
        e_bit   = r_bit;
        rej     = 1'b0;
        if (r_phase == PH_IDLE) begin
            if (i_req_type != REQ_TICK) begin
                e_bit = 3'd0;
                unique case (i_req_type)
                    REQ_RESET: begin
                        e_phase = PH_RST_LOW;
                        e_timer = clamp_ticks(i_cfg.reset_low_ticks);
                    end
                    REQ_WRITE: begin
                        e_shift = i_write_byte;
                        e_phase = PH_W_LOW;
                        e_timer = clamp_ticks(i_cfg.slot_low_ticks);
                    end
                    default: begin
                        e_shift = 8'd0;
                        e_phase = PH_R_LOW;
                        e_timer = clamp_ticks(i_cfg.slot_low_ticks);
                    end
                endcase
            end
        end else if (i_req_type != REQ_TICK) begin
            rej = 1'b1;
        end

        busy       = (e_phase != PH_IDLE);
        drive      = 1'b0;
        done       = 1'b0;
        n_phase    = e_phase;
        n_timer    = e_timer;
        n_shift    = e_shift;
        n_bit      = e_bit;
        n_presence = r_presence;
        n_read     = r_read;

        if (busy) begin
            // Drive low in the low phases, and in a write rest for a zero bit
            unique case (e_phase)
                PH_RST_LOW, PH_W_LOW, PH_R_LOW: drive = 1'b1;
                PH_W_REST:                      drive = ~e_shift[e_bit];
                default:                        drive = 1'b0;
            endcase

            // Count down the phase, then advance on its last tick
            if (e_timer > TIMER_WIDTH'(1)) begin
                n_timer = e_timer - TIMER_WIDTH'(1);
            end else begin
                unique case (e_phase)
                    PH_RST_LOW: begin
                        n_phase = PH_RST_WAIT;
                        n_timer = clamp_ticks(i_cfg.reset_sample_ticks);
                    end
                    PH_RST_WAIT: begin
                        n_presence = i_line_level;
                        n_phase    = PH_RST_TAIL;
                        n_timer    = clamp_ticks(i_cfg.reset_tail_ticks);
                    end
                    PH_W_LOW: begin
                        n_phase = PH_W_REST;
                        n_timer = clamp_ticks(i_cfg.write_rest_ticks);
                    end
                    PH_W_REST: begin
                        if (e_bit == 3'd7) begin
                            done = 1'b1;
                        end else begin
                            n_bit   = e_bit + 3'd1;
                            n_phase = PH_W_LOW;
                            n_timer = clamp_ticks(i_cfg.slot_low_ticks);
                        end
                    end
                    PH_R_LOW: begin
                        n_phase = PH_R_WAIT;
                        n_timer = clamp_ticks(i_cfg.read_sample_ticks);
                    end
                    PH_R_WAIT: begin
                        n_shift[e_bit] = e_shift[e_bit] | i_line_level;
                        n_phase        = PH_R_TAIL;
                        n_timer        = clamp_ticks(i_cfg.read_tail_ticks);
                    end
                    PH_R_TAIL: begin
                        if (e_bit == 3'd7) begin
                            n_read = e_shift;
                            done   = 1'b1;
                        end else begin
                            n_bit   = e_bit + 3'd1;
                            n_phase = PH_R_LOW;
                            n_timer = clamp_ticks(i_cfg.slot_low_ticks);
                        end
                    end
                    PH_RST_TAIL: begin
                        done = 1'b1;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
                // Return to idle at the end of an operation
                if (done || n_phase == PH_IDLE) begin
                    n_phase = PH_IDLE;
                    n_timer = '0;
                    n_bit   = 3'd0;
                end
            end
        end

        o_res.drive_low      = drive;
        o_res.busy_res       = busy;
        o_res.op_done        = done;
        o_res.read_byte      = n_read;
        o_res.presence_level = n_presence;
        o_res.cmd_rejected   = rej;
    end

    // Advance the bus state once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_timer    <= '0;
            r_shift    <= 8'd0;
            r_bit      <= 3'd0;
            r_presence <= 1'b1;
            r_read     <= 8'd0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_timer    <= n_timer;
            r_shift    <= n_shift;
            r_bit      <= n_bit;
            r_presence <= n_presence;
            r_read     <= n_read;
        end
    end

endmodule

// ===== hw/rtl/owb_out_reg.sv =====
module owb_out_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  owb_pkg::t_res  i_res,
    output logic           o_can_load,
    owb_out_if.source      o_res
);
    import owb_pkg::*;

    logic r_valid;
    t_res r_res;

    // Take a new result when empty or when the held one leaves this cycle
    assign o_can_load = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    // Hold the payload until the transaction completes
    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.drive_low      = r_res.drive_low;
    assign o_res.busy_res       = r_res.busy_res;
    assign o_res.op_done        = r_res.op_done;
    assign o_res.read_byte      = r_res.read_byte;
    assign o_res.presence_level = r_res.presence_level;
    assign o_res.cmd_rejected   = r_res.cmd_rejected;

endmodule
